// ----- rtl/ffa_pkg.sv -----
// Package: types, sizes and codes shared by the first-fit allocator files.
`default_nettype none
package ffa_pkg;

  localparam int POOL_BYTES   = 1048576;
  localparam int HEADER_BYTES = 12;
  localparam int MAX_SEGMENTS = 256;

  localparam int ADDR_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W  = ADDR_W + 1;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NULL   = 2'd1;
  localparam logic [1:0] ST_NOFIT  = 2'd2;
  localparam logic [1:0] ST_BADOFF = 2'd3;

  typedef struct packed {
    logic [19:0] start;
    logic [20:0] size;
    logic        free;
  } seg_t;

  localparam seg_t SEG_RESET = '{start: 20'd0,
                                 size:  21'(POOL_BYTES - HEADER_BYTES),
                                 free:  1'b1};

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    seg_t              wr_data;
  } ram_req_t;

endpackage
`default_nettype wire

// ----- rtl/ffa_req_if.sv -----
// Interface: request channel of the allocator.
`default_nettype none
interface ffa_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [20:0] request_bytes;
  logic [19:0] release_offset;

  modport source (output valid, action, request_bytes, release_offset, input ready);
  modport sink   (input valid, action, request_bytes, release_offset, output ready);
endinterface
`default_nettype wire

// ----- rtl/ffa_rsp_if.sv -----
// Interface: response channel of the allocator.
`default_nettype none
interface ffa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [19:0] payload_offset;

  modport source (output valid, status, payload_offset, input ready);
  modport sink   (input valid, status, payload_offset, output ready);
endinterface
`default_nettype wire

// ----- rtl/ffa_seg_ram.sv -----
// Segment table memory: one write port, one registered read port.
`default_nettype none
module ffa_seg_ram
  import ffa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire ram_req_t ram,
  output seg_t          rd_data
);

  seg_t mem [MAX_SEGMENTS];
  seg_t rd_q;
  logic e0_ok;
  logic rd_init;

  always_ff @(posedge clk) begin
    if (ram.wr_en) begin
      mem[ram.wr_addr] <= ram.wr_data;
    end
    if (ram.rd_en) begin
      rd_q <= mem[ram.rd_addr];
    end
  end

  // entry 0 holds its reset value until first written
  always_ff @(posedge clk) begin
    if (rst) begin
      e0_ok   <= 1'b0;
      rd_init <= 1'b0;
    end else begin
      if (ram.wr_en && ram.wr_addr == '0) begin
        e0_ok <= 1'b1;
      end
      if (ram.rd_en) begin
        rd_init <= (ram.rd_addr == '0) && !e0_ok;
      end
    end
  end

  assign rd_data = rd_init ? SEG_RESET : rd_q;

endmodule
`default_nettype wire

// ----- rtl/ffa_ctrl.sv -----
// Sequencer: scan, shift, split and merge passes over the segment table.
`default_nettype none
module ffa_ctrl
  import ffa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  ffa_req_if.sink    req,
  ffa_rsp_if.source  rsp,
  output ram_req_t   ram,
  input  wire seg_t  rd_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_SPLIT = 3'd3;
  localparam logic [2:0] S_MARK  = 3'd4;
  localparam logic [2:0] S_MERGE = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]        state;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  d_idx;
  logic [CNT_W-1:0]  sh;
  logic [CNT_W-1:0]  w;
  logic              dv;
  logic              act;
  logic [21:0]       need;
  logic [19:0]       off;
  logic [ADDR_W-1:0] idx;
  seg_t              fit;
  seg_t              acc;
  logic              have_acc;
  logic              split_r;
  logic [1:0]        res_status;
  logic [19:0]       res_off;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [19:0]       out_off;

  seg_t        e;
  logic [20:0] start_hdr;
  logic [20:0] fit_hdr;
  logic        hit;
  logic        issue;
  logic        sh_issue;
  logic        split_now;
  logic        merge_join;
  logic        merge_end;
  logic [21:0] need_in;

  assign need_in   = ({1'b0, req.request_bytes} + 22'd3) & ~22'd3;
  assign start_hdr = {1'b0, rd_data.start} + 21'(HEADER_BYTES);
  assign fit_hdr   = {1'b0, fit.start} + 21'(HEADER_BYTES);
  assign issue     = rd_idx < cnt;
  assign sh_issue  = sh > {1'b0, idx};
  assign split_now = ({1'b0, rd_data.size} > need + 22'(HEADER_BYTES))
                     && (cnt < CNT_W'(MAX_SEGMENTS));

  always_comb begin
    e = rd_data;
    if (d_idx == {1'b0, idx}) begin
      e.free = 1'b1;
    end
  end

  assign hit = dv && ((act == ACT_ALLOC)
                      ? (rd_data.free && {1'b0, rd_data.size} >= need)
                      : (start_hdr == {1'b0, off}));
  assign merge_join = have_acc && acc.free && e.free;
  assign merge_end  = !dv && !issue;

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.payload_offset = out_off;

  always_comb begin
    ram = '0;
    unique case (state)
      S_IDLE: begin
        ram.rd_en = req.valid;
      end
      S_SCAN: begin
        ram.rd_en   = issue && !hit;
        ram.rd_addr = rd_idx[ADDR_W-1:0];
      end
      S_SHIFT: begin
        ram.wr_en   = dv;
        ram.wr_addr = d_idx[ADDR_W-1:0] + 1'b1;
        ram.wr_data = rd_data;
        ram.rd_en   = sh_issue;
        ram.rd_addr = sh[ADDR_W-1:0];
      end
      S_SPLIT: begin
        ram.wr_en         = 1'b1;
        ram.wr_addr       = idx + 1'b1;
        ram.wr_data.start = fit_hdr[19:0] + need[19:0];
        ram.wr_data.size  = fit.size - need[20:0] - 21'(HEADER_BYTES);
        ram.wr_data.free  = 1'b1;
      end
      S_MARK: begin
        ram.wr_en         = 1'b1;
        ram.wr_addr       = idx;
        ram.wr_data.start = fit.start;
        ram.wr_data.size  = split_r ? need[20:0] : fit.size;
        ram.wr_data.free  = 1'b0;
      end
      S_MERGE: begin
        ram.rd_en   = issue;
        ram.rd_addr = rd_idx[ADDR_W-1:0];
        ram.wr_en   = (dv && have_acc && !merge_join) || merge_end;
        ram.wr_addr = w[ADDR_W-1:0];
        ram.wr_data = acc;
      end
      default: begin
        ram = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= CNT_W'(1);
      out_valid <= 1'b0;
      dv        <= 1'b0;
      have_acc  <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            act    <= req.action;
            need   <= need_in;
            off    <= req.release_offset;
            rd_idx <= CNT_W'(1);
            d_idx  <= '0;
            dv     <= 1'b1;
            if ((req.action == ACT_ALLOC && req.request_bytes == '0) ||
                (req.action == ACT_RELEASE && req.release_offset == '0)) begin
              res_status <= ST_NULL;
              res_off    <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            idx     <= d_idx[ADDR_W-1:0];
            fit     <= rd_data;
            split_r <= split_now;
            dv      <= 1'b0;
            if (act == ACT_ALLOC) begin
              sh    <= cnt - 1'b1;
              state <= split_now ? S_SHIFT : S_MARK;
            end else begin
              rd_idx   <= '0;
              w        <= '0;
              have_acc <= 1'b0;
              state    <= S_MERGE;
            end
          end else if (dv && d_idx == cnt - 1'b1) begin
            res_status <= (act == ACT_ALLOC) ? ST_NOFIT : ST_BADOFF;
            res_off    <= '0;
            dv         <= 1'b0;
            state      <= S_DONE;
          end else begin
            dv     <= issue;
            d_idx  <= rd_idx;
            rd_idx <= rd_idx + CNT_W'(issue);
          end
        end
        S_SHIFT: begin
          dv    <= sh_issue;
          d_idx <= sh;
          if (sh_issue) begin
            sh <= sh - 1'b1;
          end
          if (!dv && !sh_issue) begin
            state <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          state <= S_MARK;
        end
        S_MARK: begin
          cnt        <= cnt + CNT_W'(split_r);
          res_status <= ST_OK;
          res_off    <= fit_hdr[19:0];
          state      <= S_DONE;
        end
        S_MERGE: begin
          dv     <= issue;
          d_idx  <= rd_idx;
          rd_idx <= rd_idx + CNT_W'(issue);
          if (dv) begin
            if (!have_acc) begin
              acc      <= e;
              have_acc <= 1'b1;
            end else if (merge_join) begin
              acc.size <= acc.size + e.size + 21'(HEADER_BYTES);
            end else begin
              acc <= e;
              w   <= w + 1'b1;
            end
          end
          if (merge_end) begin
            cnt        <= w + 1'b1;
            res_status <= ST_OK;
            res_off    <= '0;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_off    <= res_off;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/first_fit_heap_allocator_top.sv -----
// First-fit heap allocator with full coalescing of free segments.
//
// Channels: req (sink) takes an action (allocate or release), a byte count
// and a payload offset; rsp (source) returns a status and a payload offset,
// one response per request, in order. Both use valid/ready.
// The segment table lives in a single-port-write, registered-read memory.
// Path from acceptance to the response register, n segments in use:
//   zero size or null offset: answered without a scan;
//   no fit or unknown offset: after a scan of all n entries;
//   allocate hit at entry i: scan to i, then a shift pass if it splits;
//   release hit at entry i: scan to i, then a merge pass over all n.
// These passes share one memory read port: one request in flight at a time.
// A new request is taken while the last response still waits in the output
// register; if the receiver stalls, the next result waits until it drains.
// Reset (rst, synchronous) leaves one free segment covering the pool and
// empties the output register; no clearing pass is needed.
`default_nettype none
module first_fit_heap_allocator_top
  import ffa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  ffa_req_if.sink   req,
  ffa_rsp_if.source rsp
);

  ram_req_t ram;
  seg_t     rd_data;

  ffa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .ram     (ram),
    .rd_data (rd_data)
  );

  ffa_seg_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .ram     (ram),
    .rd_data (rd_data)
  );

endmodule
`default_nettype wire

// ----- rtl/ffa_checker.sv -----
// Port-level checker for the allocator, bound to the top level.
`default_nettype none
module ffa_checker
  import ffa_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [1:0]  rsp_status,
  input wire logic [19:0] rsp_payload_offset
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_payload_offset == '0)
    else $error("failed request returned an offset");

  a_aligned: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_payload_offset[1:0] == 2'b00)
    else $error("payload offset not word aligned");

endmodule

bind first_fit_heap_allocator_top ffa_checker u_ffa_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_payload_offset (rsp.payload_offset)
);
`default_nettype wire
